@@ design/fld_pkg.sv @@
// Package for the four-level feedback dispatcher.
// Holds field widths, the job record type, queue control type, FSM states and helpers.
// No dependencies; every other design file uses it by scoped names.
package fld_pkg;

  // Widths of the fixed fields on the ports.
  localparam int unsigned ID_W       = 6;
  localparam int unsigned LEVEL_W    = 2;
  localparam int unsigned BURST_W    = 16;
  localparam int unsigned NUM_LEVELS = 4;
  localparam int unsigned NUM_IDS    = 64;

  // Level numbering: level 0 runs to completion, level 3 is the floor.
  localparam logic [LEVEL_W-1:0] SYSTEM_LEVEL = 2'd0;
  localparam logic [LEVEL_W-1:0] LOWEST_LEVEL = 2'd3;

  // Input action codes.
  localparam logic ACT_ARRIVE = 1'b0;
  localparam logic ACT_TICK   = 1'b1;

  // One entry of the job memory.
  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [BURST_W-1:0] remaining;
    logic               started;
  } fld_job_t;

  // Control word from the sequencer to the queue bank.
  typedef struct packed {
    logic               push;
    logic [LEVEL_W-1:0] push_level;
    logic               pop;
    logic [LEVEL_W-1:0] pop_level;
  } fld_q_ctl_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_POP,
    S_DISP,
    S_RESULT
  } fld_state_e;

  // Remaining time after one tick, held at zero.
  function automatic logic [BURST_W-1:0] dec_sat(input logic [BURST_W-1:0] v);
    dec_sat = (v == '0) ? v : v - 1'b1;
  endfunction

  // Level after a preemption, held at the lowest level.
  function automatic logic [LEVEL_W-1:0] demote(input logic [LEVEL_W-1:0] lv);
    demote = (lv == LOWEST_LEVEL) ? lv : lv + 1'b1;
  endfunction

endpackage

@@ design/fld_ifs.sv @@
// Valid/ready channel interfaces for the dispatcher input and result words.
// Depends on fld_pkg for the field widths.

interface fld_in_if;
  logic                        valid;
  logic                        ready;
  logic                        action;
  logic [fld_pkg::ID_W-1:0]    job_id;
  logic [fld_pkg::LEVEL_W-1:0] arrival_priority;
  logic [fld_pkg::BURST_W-1:0] burst_ticks;

  modport source (output valid, action, job_id, arrival_priority, burst_ticks, input ready);
  modport sink   (input valid, action, job_id, arrival_priority, burst_ticks, output ready);
endinterface

interface fld_out_if;
  logic                     valid;
  logic                     ready;
  logic                     accepted;
  logic                     ended_valid;
  logic [fld_pkg::ID_W-1:0] ended_id;
  logic                     preempted_valid;
  logic [fld_pkg::ID_W-1:0] preempted_id;
  logic                     dispatched_valid;
  logic [fld_pkg::ID_W-1:0] dispatched_id;
  logic                     dispatched_resumed;
  logic                     running_valid;
  logic [fld_pkg::ID_W-1:0] running_id;

  modport source (output valid, accepted, ended_valid, ended_id, preempted_valid,
                  preempted_id, dispatched_valid, dispatched_id, dispatched_resumed,
                  running_valid, running_id, input ready);
  modport sink   (input valid, accepted, ended_valid, ended_id, preempted_valid,
                  preempted_id, dispatched_valid, dispatched_id, dispatched_resumed,
                  running_valid, running_id, output ready);
endinterface

@@ design/fld_queue_bank.sv @@
// Four ready queues of job ids sharing one synchronous store, one push and one pop a cycle.
// Depends on fld_pkg for the control word and level constants.
module fld_queue_bank #(
  parameter int unsigned MAX_JOBS = 64
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  fld_pkg::fld_q_ctl_t                   ctl_i,
  input  logic [$clog2(MAX_JOBS)-1:0]           push_id_i,
  output logic [$clog2(MAX_JOBS)-1:0]           pop_id_o,
  output logic [fld_pkg::NUM_LEVELS-1:0]        nonempty_o
);

  localparam int unsigned IDX_W = $clog2(MAX_JOBS);
  localparam int unsigned CNT_W = $clog2(MAX_JOBS + 1);
  localparam int unsigned ADR_W = fld_pkg::LEVEL_W + IDX_W;
  localparam int unsigned DEPTH = fld_pkg::NUM_LEVELS << IDX_W;

  logic [IDX_W-1:0] store_q [DEPTH];
  logic [IDX_W-1:0] head_q  [fld_pkg::NUM_LEVELS];
  logic [IDX_W-1:0] tail_q  [fld_pkg::NUM_LEVELS];
  logic [CNT_W-1:0] count_q [fld_pkg::NUM_LEVELS];
  logic [IDX_W-1:0] head_d  [fld_pkg::NUM_LEVELS];
  logic [IDX_W-1:0] tail_d  [fld_pkg::NUM_LEVELS];
  logic [CNT_W-1:0] count_d [fld_pkg::NUM_LEVELS];
  logic             push_ok;
  logic             pop_ok;
  logic [IDX_W-1:0] rd_id_q;

  // A push into a full queue is dropped, a pop from an empty one does nothing.
  assign push_ok = ctl_i.push && (count_q[ctl_i.push_level] != CNT_W'(MAX_JOBS));
  assign pop_ok  = ctl_i.pop && (count_q[ctl_i.pop_level] != '0);

  // Pointer and count updates for each level; both may move in one cycle.
  always_comb begin
    for (int l = 0; l < fld_pkg::NUM_LEVELS; l++) begin
      head_d[l]  = head_q[l];
      tail_d[l]  = tail_q[l];
      count_d[l] = count_q[l];
      if (push_ok && (ctl_i.push_level == fld_pkg::LEVEL_W'(l))) begin
        tail_d[l]  = (tail_q[l] == IDX_W'(MAX_JOBS - 1)) ? '0 : tail_q[l] + 1'b1;
        count_d[l] = count_d[l] + 1'b1;
      end
      if (pop_ok && (ctl_i.pop_level == fld_pkg::LEVEL_W'(l))) begin
        head_d[l]  = (head_q[l] == IDX_W'(MAX_JOBS - 1)) ? '0 : head_q[l] + 1'b1;
        count_d[l] = count_d[l] - 1'b1;
      end
      nonempty_o[l] = (count_q[l] != '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int l = 0; l < fld_pkg::NUM_LEVELS; l++) begin
        head_q[l]  <= '0;
        tail_q[l]  <= '0;
        count_q[l] <= '0;
      end
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  // Shared id store: write at the pushed tail, registered read at the popped head.
  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      store_q[ADR_W'({ctl_i.push_level, tail_q[ctl_i.push_level]})] <= push_id_i;
    end
    if (pop_ok) begin
      rd_id_q <= store_q[ADR_W'({ctl_i.pop_level, head_q[ctl_i.pop_level]})];
    end
  end

  assign pop_id_o = rd_id_q;

`ifndef NO_ASSERTIONS
  // The sequencer only pops a level it has seen holding a word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.pop |-> count_q[ctl_i.pop_level] != '0)
    else $error("pop from an empty level");

  // Live jobs never outnumber the queue depth, so no push is ever dropped.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.push |-> count_q[ctl_i.push_level] != CNT_W'(MAX_JOBS))
    else $error("push into a full level");
`endif

endmodule

@@ design/four_level_feedback_dispatcher.sv @@
// Top level of the four-level feedback dispatcher: sequencer, job memory and live bits.
// Depends on fld_pkg, the fld_in_if/fld_out_if interfaces and fld_queue_bank.
//
//   Channel | Direction | Word
//   in_i    | sink      | action, job_id, arrival_priority, burst_ticks
//   out_o   | source    | accepted, ended/preempted/dispatched fields, running_valid/id
//
// An arrival goes straight to the result state; a tick first reads the running job's
// record. A dispatching tick then pops the chosen queue, reads the popped job's record
// and writes it back, each read a registered one. The sequencer returns to idle as the
// result register loads and then takes a new word even while that register holds an
// untaken one; a stalled output holds the sequencer in its result state. Reset clears
// the live bits, queues and sequencer.
module four_level_feedback_dispatcher #(
  parameter int unsigned MAX_JOBS = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  fld_in_if.sink    in_i,
  fld_out_if.source out_o
);

  localparam int unsigned IDX_W = $clog2(MAX_JOBS);
  localparam int unsigned ID_W  = fld_pkg::ID_W;

  fld_pkg::fld_state_e state_q, state_d;

  // Job memory: level, remaining time and started flag for each id.
  fld_pkg::fld_job_t job_mem_q [MAX_JOBS];
  fld_pkg::fld_job_t job_rdata_q;
  fld_pkg::fld_job_t job_wdata;
  logic              job_we, job_re;
  logic [IDX_W-1:0]  job_waddr, job_raddr;

  logic [fld_pkg::NUM_IDS-1:0] live_q, live_d;
  logic [IDX_W-1:0]            cur_q, cur_d;
  logic                        cv_q, cv_d;
  logic                        sys_q, sys_d;
  logic [fld_pkg::LEVEL_W-1:0] sel_q, sel_d;

  // Result being built.
  logic             res_acc_q, res_acc_d;
  logic             res_e_v_q, res_e_v_d;
  logic             res_p_v_q, res_p_v_d;
  logic [IDX_W-1:0] res_old_id_q, res_old_id_d;
  logic             res_d_v_q, res_d_v_d;
  logic             res_d_res_q, res_d_res_d;

  // Output register.
  logic            out_valid_q, out_valid_d;
  logic            out_load;
  logic            out_acc_q, out_e_v_q, out_p_v_q, out_d_v_q, out_d_res_q, out_r_v_q;
  logic [ID_W-1:0] out_e_id_q, out_p_id_q, out_d_id_q, out_r_id_q;

  // Queue bank connection.
  fld_pkg::fld_q_ctl_t         q_ctl;
  logic [IDX_W-1:0]            q_push_id;
  logic [IDX_W-1:0]            q_pop_id;
  logic [fld_pkg::NUM_LEVELS-1:0] q_nonempty;

  // Id width conversions between the 6-bit port field and the table index.
  logic [IDX_W+ID_W-1:0] in_id_ext, cur_ext, old_ext;
  logic [IDX_W-1:0]      in_idx;
  logic [ID_W-1:0]       cur_id, old_id;
  logic                  in_range;
  logic                  in_fire;

  assign in_id_ext = {{IDX_W{1'b0}}, in_i.job_id};
  assign in_idx    = in_id_ext[IDX_W-1:0];
  assign cur_ext   = {{ID_W{1'b0}}, cur_q};
  assign cur_id    = cur_ext[ID_W-1:0];
  assign old_ext   = {{ID_W{1'b0}}, res_old_id_q};
  assign old_id    = old_ext[ID_W-1:0];
  assign in_range  = ({{(32 - ID_W){1'b0}}, in_i.job_id} < 32'(MAX_JOBS));

  assign in_i.ready = (state_q == fld_pkg::S_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;

  fld_queue_bank #(
    .MAX_JOBS (MAX_JOBS)
  ) u_queues (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (q_ctl),
    .push_id_i  (q_push_id),
    .pop_id_o   (q_pop_id),
    .nonempty_o (q_nonempty)
  );

  // Sequencer: next state, memory accesses and queue commands.
  always_comb begin
    logic                        ended;
    logic                        cv_a, sys_a;
    logic                        sel_v;
    logic [fld_pkg::LEVEL_W-1:0] sel;
    logic [fld_pkg::LEVEL_W-1:0] new_lv;

    state_d      = state_q;
    live_d       = live_q;
    cur_d        = cur_q;
    cv_d         = cv_q;
    sys_d        = sys_q;
    sel_d        = sel_q;
    res_acc_d    = res_acc_q;
    res_e_v_d    = res_e_v_q;
    res_p_v_d    = res_p_v_q;
    res_old_id_d = res_old_id_q;
    res_d_v_d    = res_d_v_q;
    res_d_res_d  = res_d_res_q;
    job_we       = 1'b0;
    job_waddr    = cur_q;
    job_wdata    = job_rdata_q;
    job_re       = 1'b0;
    job_raddr    = cur_q;
    q_ctl        = '0;
    q_push_id    = cur_q;
    out_load     = 1'b0;

    ended  = cv_q && (job_rdata_q.remaining == '0);
    cv_a   = cv_q && !ended;
    sys_a  = sys_q && !ended;
    sel_v  = !sys_a && (q_nonempty != '0);
    sel    = fld_pkg::LOWEST_LEVEL;
    for (int l = fld_pkg::NUM_LEVELS - 1; l >= 0; l--) begin
      if (q_nonempty[l]) begin
        sel = fld_pkg::LEVEL_W'(l);
      end
    end
    new_lv = fld_pkg::demote(job_rdata_q.level);

    unique case (state_q)
      fld_pkg::S_IDLE: begin
        if (in_fire) begin
          res_acc_d   = 1'b1;
          res_e_v_d   = 1'b0;
          res_p_v_d   = 1'b0;
          res_d_v_d   = 1'b0;
          res_d_res_d = 1'b0;
          if (in_i.action == fld_pkg::ACT_ARRIVE) begin
            // Arrival: record the job and queue it at its starting level.
            if (!in_range || live_q[in_i.job_id]) begin
              res_acc_d = 1'b0;
            end else begin
              live_d[in_i.job_id] = 1'b1;
              job_we              = 1'b1;
              job_waddr           = in_idx;
              job_wdata.level     = in_i.arrival_priority;
              job_wdata.remaining = (in_i.burst_ticks == '0) ? fld_pkg::BURST_W'(1)
                                                             : in_i.burst_ticks;
              job_wdata.started   = 1'b0;
              q_ctl.push          = 1'b1;
              q_ctl.push_level    = in_i.arrival_priority;
              q_push_id           = in_idx;
            end
            state_d = fld_pkg::S_RESULT;
          end else begin
            // Tick: fetch the running job's record.
            job_re  = 1'b1;
            state_d = fld_pkg::S_EVAL;
          end
        end
      end

      fld_pkg::S_EVAL: begin
        res_old_id_d = cur_q;
        // A finished job leaves the processor before anything else happens.
        cv_d         = cv_a;
        sys_d        = sys_a;
        if (ended) begin
          live_d[cur_id] = 1'b0;
          res_e_v_d      = 1'b1;
        end
        if (sel_v) begin
          // Preempt a running user job, then pop the chosen level.
          if (cv_a) begin
            job_we              = 1'b1;
            job_wdata.level     = new_lv;
            job_wdata.started   = 1'b1;
            q_ctl.push          = 1'b1;
            q_ctl.push_level    = new_lv;
            res_p_v_d           = 1'b1;
          end
          q_ctl.pop       = 1'b1;
          q_ctl.pop_level = sel;
          sel_d           = sel;
          state_d         = fld_pkg::S_POP;
        end else begin
          // Nothing to dispatch: the running job keeps going.
          if (cv_a) begin
            job_we              = 1'b1;
            job_wdata.remaining = fld_pkg::dec_sat(job_rdata_q.remaining);
          end
          state_d = fld_pkg::S_RESULT;
        end
      end

      fld_pkg::S_POP: begin
        job_re    = 1'b1;
        job_raddr = q_pop_id;
        cur_d     = q_pop_id;
        cv_d      = 1'b1;
        sys_d     = (sel_q == fld_pkg::SYSTEM_LEVEL);
        res_d_v_d = 1'b1;
        state_d   = fld_pkg::S_DISP;
      end

      fld_pkg::S_DISP: begin
        // Mark the dispatched job started and charge it this tick.
        res_d_res_d         = job_rdata_q.started;
        job_we              = 1'b1;
        job_wdata.remaining = fld_pkg::dec_sat(job_rdata_q.remaining);
        job_wdata.started   = 1'b1;
        state_d             = fld_pkg::S_RESULT;
      end

      fld_pkg::S_RESULT: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = fld_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = fld_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fld_pkg::S_IDLE;
      live_q  <= '0;
      cur_q   <= '0;
      cv_q    <= 1'b0;
      sys_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      live_q  <= live_d;
      cur_q   <= cur_d;
      cv_q    <= cv_d;
      sys_q   <= sys_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sel_q        <= sel_d;
    res_acc_q    <= res_acc_d;
    res_e_v_q    <= res_e_v_d;
    res_p_v_q    <= res_p_v_d;
    res_old_id_q <= res_old_id_d;
    res_d_v_q    <= res_d_v_d;
    res_d_res_q  <= res_d_res_d;
  end

  // Job memory with one write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (job_we) begin
      job_mem_q[job_waddr] <= job_wdata;
    end
    if (job_re) begin
      job_rdata_q <= job_mem_q[job_raddr];
    end
  end

  // Output register: loaded from the finished result, held while stalled.
  assign out_valid_d = out_load || (out_valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_acc_q   <= res_acc_q;
      out_e_v_q   <= res_e_v_q;
      out_e_id_q  <= res_e_v_q ? old_id : '0;
      out_p_v_q   <= res_p_v_q;
      out_p_id_q  <= res_p_v_q ? old_id : '0;
      out_d_v_q   <= res_d_v_q;
      out_d_id_q  <= res_d_v_q ? cur_id : '0;
      out_d_res_q <= res_d_v_q && res_d_res_q;
      out_r_v_q   <= cv_q;
      out_r_id_q  <= cv_q ? cur_id : '0;
    end
  end

  assign out_o.valid              = out_valid_q;
  assign out_o.accepted           = out_acc_q;
  assign out_o.ended_valid        = out_e_v_q;
  assign out_o.ended_id           = out_e_id_q;
  assign out_o.preempted_valid    = out_p_v_q;
  assign out_o.preempted_id       = out_p_id_q;
  assign out_o.dispatched_valid   = out_d_v_q;
  assign out_o.dispatched_id      = out_d_id_q;
  assign out_o.dispatched_resumed = out_d_res_q;
  assign out_o.running_valid      = out_r_v_q;
  assign out_o.running_id         = out_r_id_q;

`ifndef NO_ASSERTIONS
  // A system job holding the processor is always the running job.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sys_q |-> cv_q)
    else $error("system flag set with no running job");

  // The running job is always live.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cv_q |-> live_q[cur_id])
    else $error("running job is not live");

  // The sequencer never reads and writes the same job entry in one cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (job_we && job_re) |-> (job_waddr != job_raddr))
    else $error("job memory read and write collide");

  // A dispatch always leaves a running job.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fld_pkg::S_DISP) |-> (cv_q && res_d_v_q))
    else $error("dispatch without a running job");
`endif

endmodule

@@ test/four_level_feedback_dispatcher_checker.sv @@
// Scoreboard for the four-level feedback dispatcher: it predicts the result word of
// every accepted input word and compares it with each word the block delivers.
// Depends on fld_pkg and the fld_in_if/fld_out_if channel interfaces.
module fld_schedule_checker (
  input  logic clk_i,
  input  logic rst_ni,
  fld_in_if    in_mon_i,
  fld_out_if   out_mon_i,
  output int   fail_count_o,
  output int   pending_o
);
  import fld_pkg::*;

  // One result word, in port order.
  typedef struct packed {
    logic            accepted;
    logic            ended_valid;
    logic [ID_W-1:0] ended_id;
    logic            preempted_valid;
    logic [ID_W-1:0] preempted_id;
    logic            dispatched_valid;
    logic [ID_W-1:0] dispatched_id;
    logic            dispatched_resumed;
    logic            running_valid;
    logic [ID_W-1:0] running_id;
  } outcome_t;

  // Shadow copy of the job records and the four level queues.
  logic [LEVEL_W-1:0] job_level   [NUM_IDS];
  logic [BURST_W-1:0] job_left    [NUM_IDS];
  logic               job_started [NUM_IDS];
  logic               job_live    [NUM_IDS];
  logic [ID_W-1:0]    level_ring  [NUM_LEVELS][NUM_IDS];
  int unsigned        ring_head   [NUM_LEVELS];
  int unsigned        ring_tail   [NUM_LEVELS];
  int unsigned        ring_count  [NUM_LEVELS];
  logic [ID_W-1:0]    run_id;
  logic               run_valid;
  logic               run_system;

  outcome_t expected_outcomes[$];
  int       failures;

  // Append a job to the tail of a level queue; a full queue drops the push.
  function automatic void enqueue_job(input logic [LEVEL_W-1:0] lvl,
                                      input logic [ID_W-1:0] id);
    if (ring_count[lvl] < NUM_IDS) begin
      level_ring[lvl][ring_tail[lvl]] = id;
      ring_tail[lvl] = (ring_tail[lvl] + 1) % NUM_IDS;
      ring_count[lvl]++;
    end
  endfunction

  // Advance the shadow schedule by one input word and return its result word.
  function automatic outcome_t predict_outcome(input logic act,
                                               input logic [ID_W-1:0] id,
                                               input logic [LEVEL_W-1:0] prio,
                                               input logic [BURST_W-1:0] burst);
    outcome_t           o;
    int                 sel;
    int                 l;
    logic [LEVEL_W-1:0] lv;
    logic [ID_W-1:0]    nid;
    o = '0;
    o.accepted = 1'b1;
    sel = -1;
    if (act == ACT_ARRIVE) begin
      // A live id is turned away; a zero burst counts as one tick.
      if (job_live[id]) begin
        o.accepted = 1'b0;
      end else begin
        job_live[id] = 1'b1;
        job_level[id] = prio;
        job_left[id] = (burst == '0) ? BURST_W'(1) : burst;
        job_started[id] = 1'b0;
        enqueue_job(prio, id);
      end
    end else begin
      // The running job leaves once its time is used up.
      if (run_valid && job_left[run_id] == '0) begin
        o.ended_valid = 1'b1;
        o.ended_id = run_id;
        job_live[run_id] = 1'b0;
        run_valid = 1'b0;
        run_system = 1'b0;
      end
      // Pick the highest non-empty level unless a system job holds the processor.
      if (!run_system) begin
        for (l = 0; l < NUM_LEVELS; l++) begin
          if (sel < 0 && ring_count[l] != 0) sel = l;
        end
      end
      if (sel >= 0) begin
        // The user job in hand drops one level and goes to the tail of that queue.
        if (run_valid) begin
          lv = (job_level[run_id] == LOWEST_LEVEL) ? LOWEST_LEVEL : job_level[run_id] + 1'b1;
          job_level[run_id] = lv;
          enqueue_job(lv, run_id);
          o.preempted_valid = 1'b1;
          o.preempted_id = run_id;
        end
        nid = level_ring[sel][ring_head[sel]];
        ring_head[sel] = (ring_head[sel] + 1) % NUM_IDS;
        ring_count[sel]--;
        o.dispatched_valid = 1'b1;
        o.dispatched_id = nid;
        o.dispatched_resumed = job_started[nid];
        job_started[nid] = 1'b1;
        run_id = nid;
        run_valid = 1'b1;
        run_system = (sel == int'(SYSTEM_LEVEL));
      end
      // One tick of work, held at zero.
      if (run_valid && job_left[run_id] != '0) job_left[run_id] = job_left[run_id] - 1'b1;
    end
    o.running_valid = run_valid;
    o.running_id = run_valid ? run_id : '0;
    return o;
  endfunction

  function automatic string describe(input outcome_t o);
    return $sformatf("acc=%0d end=%0d/%0d pre=%0d/%0d disp=%0d/%0d res=%0d run=%0d/%0d",
                     o.accepted, o.ended_valid, o.ended_id, o.preempted_valid,
                     o.preempted_id, o.dispatched_valid, o.dispatched_id,
                     o.dispatched_resumed, o.running_valid, o.running_id);
  endfunction

  // Predict on each accepted input word, then check each accepted result word.
  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t seen;
    outcome_t want;
    if (!rst_ni) begin
      for (int i = 0; i < NUM_IDS; i++) job_live[i] = 1'b0;
      for (int i = 0; i < NUM_LEVELS; i++) begin
        ring_head[i] = 0;
        ring_tail[i] = 0;
        ring_count[i] = 0;
      end
      run_id = '0;
      run_valid = 1'b0;
      run_system = 1'b0;
      expected_outcomes.delete();
      failures = 0;
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (in_mon_i.valid && in_mon_i.ready) begin
        expected_outcomes.push_back(predict_outcome(in_mon_i.action, in_mon_i.job_id,
                                                    in_mon_i.arrival_priority,
                                                    in_mon_i.burst_ticks));
      end
      if (out_mon_i.valid && out_mon_i.ready) begin
        seen = {out_mon_i.accepted, out_mon_i.ended_valid, out_mon_i.ended_id,
                out_mon_i.preempted_valid, out_mon_i.preempted_id,
                out_mon_i.dispatched_valid, out_mon_i.dispatched_id,
                out_mon_i.dispatched_resumed, out_mon_i.running_valid,
                out_mon_i.running_id};
        if (expected_outcomes.size() == 0) begin
          if (failures < 10) $display("unexpected word: %s", describe(seen));
          failures++;
        end else begin
          want = expected_outcomes.pop_front();
          if (seen !== want) begin
            if (failures < 10) begin
              $display("mismatch: expected %s", describe(want));
              $display("          actual   %s", describe(seen));
            end
            failures++;
          end
        end
      end
      pending_o <= expected_outcomes.size();
      fail_count_o <= failures;
    end
  end

endmodule

@@ test/four_level_feedback_dispatcher_test.sv @@
// Testbench top for the four-level feedback dispatcher: clock, reset, stimulus and
// the result-side ready pattern; the verdict comes from fld_schedule_checker.
// Depends on fld_pkg, the channel interfaces, the block and the checker.
module four_level_feedback_dispatcher_test;
  import fld_pkg::*;

  localparam int RANDOM_ITEMS = 1750;
  localparam int SEGMENT_ITEMS = 50;
  localparam int HOLD_CYCLES = 80;
  localparam int CYCLE_LIMIT = 300000;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending_count;
  int   cycle_count;
  bit   idle_on;
  bit   hold_req;

  fld_in_if  in_ch ();
  fld_out_if out_ch ();

  four_level_feedback_dispatcher DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  fld_schedule_checker u_schedule_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon_i     (in_ch),
    .out_mon_i    (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Offer one word, maybe after a short gap, and return at the edge that takes it.
  task automatic offer_word(input logic act, input logic [ID_W-1:0] id,
                            input logic [LEVEL_W-1:0] prio,
                            input logic [BURST_W-1:0] burst);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.action <= act;
    in_ch.job_id <= id;
    in_ch.arrival_priority <= prio;
    in_ch.burst_ticks <= burst;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  // Mostly short jobs, some zero bursts and a rare very long one.
  task automatic offer_random_word(input int unsigned tick_pct);
    logic [BURST_W-1:0] burst;
    int unsigned        pick;
    pick = $urandom_range(0, 199);
    if (pick == 0) burst = BURST_W'($urandom_range(0, 65535));
    else if (pick < 12) burst = '0;
    else burst = BURST_W'($urandom_range(1, 6));
    offer_word(($urandom_range(0, 99) < tick_pct) ? ACT_TICK : ACT_ARRIVE,
               ID_W'($urandom_range(0, NUM_IDS - 1)), LEVEL_W'($urandom_range(0, 3)), burst);
  endtask

  // Stop offering and wait until every predicted word has come back.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    wait (pending_count == 0);
    @(posedge clk_i);
  endtask

  // Result side: random stalls, plus one long hold-off when asked.
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
        out_ch.ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog on the total run length.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  // Stimulus: directed opening, then random segments, then the verdict.
  initial begin
    int unsigned tick_pct;
    idle_on = 1'b1;
    hold_req = 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.action <= ACT_ARRIVE;
    in_ch.job_id <= '0;
    in_ch.arrival_priority <= '0;
    in_ch.burst_ticks <= '0;
    rst_ni <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Tick with nothing queued, ignored fields all ones.
    offer_word(ACT_TICK, 6'h3F, 2'd3, 16'hFFFF);
    // Extreme ids and bursts, a live id turned away, a zero burst.
    offer_word(ACT_ARRIVE, 6'd0, 2'd0, 16'd1);
    offer_word(ACT_ARRIVE, 6'd63, 2'd3, 16'hFFFF);
    offer_word(ACT_ARRIVE, 6'd0, 2'd2, 16'd5);
    offer_word(ACT_ARRIVE, 6'd5, 2'd1, 16'd0);
    offer_word(ACT_ARRIVE, 6'd6, 2'd2, 16'd2);
    // System job starts; a second system job waits for it to end, then holds off the user levels.
    offer_word(ACT_TICK, 6'd0, 2'd0, 16'd0);
    offer_word(ACT_ARRIVE, 6'd9, 2'd0, 16'd2);
    offer_word(ACT_TICK, 6'd0, 2'd0, 16'd0);
    offer_word(ACT_TICK, 6'd0, 2'd0, 16'd0);
    // User levels: end, preempt with demotion, floor at the lowest level, resume.
    offer_word(ACT_TICK, 6'd0, 2'd0, 16'd0);
    offer_word(ACT_TICK, 6'd0, 2'd0, 16'd0);
    offer_word(ACT_TICK, 6'd0, 2'd0, 16'd0);
    offer_word(ACT_TICK, 6'd0, 2'd0, 16'd0);
    offer_word(ACT_TICK, 6'd0, 2'd0, 16'd0);
    // More arrivals at user and system levels preempt the running job.
    offer_word(ACT_TICK, 6'd0, 2'd0, 16'd0);
    offer_word(ACT_ARRIVE, 6'd42, 2'd1, 16'd3);
    offer_word(ACT_TICK, 6'd0, 2'd0, 16'd0);
    offer_word(ACT_TICK, 6'd0, 2'd0, 16'd0);
    offer_word(ACT_ARRIVE, 6'd21, 2'd0, 16'd1);
    offer_word(ACT_TICK, 6'd0, 2'd0, 16'd0);
    offer_word(ACT_TICK, 6'd0, 2'd0, 16'd0);
    drain_results();

    // Random segments with their own mix of ticks and arrivals.
    tick_pct = 50;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % SEGMENT_ITEMS == 0) begin
        tick_pct = $urandom_range(25, 75);
        idle_on = (n < RANDOM_ITEMS - 250) && ($urandom_range(0, 3) != 0);
      end
      // The receiver holds off while words keep coming, so the block backs up.
      if (n == 400) hold_req = 1'b1;
      // The sender goes quiet until every result is back.
      if (n == 900) drain_results();
      offer_random_word(tick_pct);
    end

    drain_results();
    repeat (16) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/fld_pkg.sv
design/fld_ifs.sv
design/fld_queue_bank.sv
design/four_level_feedback_dispatcher.sv
test/four_level_feedback_dispatcher_checker.sv
test/four_level_feedback_dispatcher_test.sv
